### design/ppm_p6_header_parser_top_macros.svh
// ---------------------------------------------------------------------------
// ppm_p6_header_parser_top_macros.svh
// Assertion macros used by the checker file of the P6 header parser.
// ---------------------------------------------------------------------------
`ifndef PPM_P6_HEADER_PARSER_TOP_MACROS_SVH
`define PPM_P6_HEADER_PARSER_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PPMP6_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define PPMP6_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/ppmp6_pkg.sv
// ---------------------------------------------------------------------------
// ppmp6_pkg
// Types, codes and character helpers for the P6 header parser.
// ---------------------------------------------------------------------------
`default_nettype none

package ppmp6_pkg;

    localparam int NUMBER_BITS_DEF     = 16;
    localparam int BYTES_PER_PIXEL_DEF = 3;
    localparam int COUNT_W             = 34;
    localparam int FIELD_W             = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_MAGIC  = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_ERROR  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_HEADER = 3'd0,
        ST_PIXEL  = 3'd1,
        ST_ERROR  = 3'd2,
        ST_ACCEPT = 3'd3,
        ST_REJECT = 3'd4
    } status_t;

    localparam logic [1:0] MPOS_FIRST  = 2'd0;
    localparam logic [1:0] MPOS_SECOND = 2'd1;
    localparam logic [1:0] MPOS_THIRD  = 2'd2;

    localparam logic [1:0] FLD_WIDTH  = 2'd0;
    localparam logic [1:0] FLD_HEIGHT = 2'd1;
    localparam logic [1:0] FLD_MAXVAL = 2'd2;
    localparam logic [1:0] FLD_DONE   = 2'd3;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] magic_pos;
        logic [1:0] field_idx;
        logic       in_comment;
        logic       in_number;
        logic       sign_seen;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        phase:      PH_MAGIC,
        magic_pos:  MPOS_FIRST,
        field_idx:  FLD_WIDTH,
        in_comment: 1'b0,
        in_number:  1'b0,
        sign_seen:  1'b0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

### design/ppmp6_if.sv
// ---------------------------------------------------------------------------
// ppmp6_if
// Valid/ready channels: file bytes in, per-byte results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface ppmp6_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ppmp6_result_if;
    logic                               valid;
    logic                               ready;
    ppmp6_pkg::status_t                 status;
    logic [7:0]                         pixel_byte;
    logic [ppmp6_pkg::FIELD_W-1:0]      image_width;
    logic [ppmp6_pkg::FIELD_W-1:0]      image_height;
    logic [ppmp6_pkg::FIELD_W-1:0]      max_value;

    modport source (output valid, output status, output pixel_byte, output image_width,
                    output image_height, output max_value, input ready);
    modport sink   (input valid, input status, input pixel_byte, input image_width,
                    input image_height, input max_value, output ready);
endinterface

`default_nettype wire

### design/ppm_p6_header_parser_top.sv
// ---------------------------------------------------------------------------
// ppm_p6_header_parser_top
// Streaming P6 header parser with pixel byte pass-through and size check.
// ---------------------------------------------------------------------------
// Takes one file byte per cycle and returns one result per byte, in order.
// A byte passes the input register, then the result register; a new byte can be
// taken every cycle, limited only by backpressure on the result channel. The
// whole scanner state update for a byte is combinational logic. The required
// byte count width*height*BYTES_PER_PIXEL is formed by a two-stage registered
// multiplier from the stored width and height, ready before the first pixel
// byte. After a byte marked last the parser returns to its reset state.
`default_nettype none

module ppm_p6_header_parser_top #(
    parameter int NUMBER_BITS     = ppmp6_pkg::NUMBER_BITS_DEF,
    parameter int BYTES_PER_PIXEL = ppmp6_pkg::BYTES_PER_PIXEL_DEF
) (
    input wire logic       clk,
    input wire logic       rst_n,
    ppmp6_byte_if.sink     byte_stream,
    ppmp6_result_if.source result
);

    localparam int NB     = NUMBER_BITS;
    localparam int CW     = ppmp6_pkg::COUNT_W;
    localparam int PROD_W = 2 * NB;
    localparam int EXT_W  = (PROD_W > CW) ? PROD_W : CW;
    localparam int NEED_W = CW + 3;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // scanner state
    ppmp6_pkg::ctrl_t ctrl_reg;
    logic [NB-1:0]    acc_reg;
    logic [NB-1:0]    width_reg;
    logic [NB-1:0]    height_reg;
    logic [NB-1:0]    maxval_reg;
    logic [CW-1:0]    count_reg;

    // size product
    logic [PROD_W-1:0] prod_reg;
    logic [NEED_W-1:0] need_reg;
    logic              prod_big_reg;
    logic [EXT_W-1:0]  prod_ext;

    // result stage
    logic                            out_valid_reg;
    ppmp6_pkg::status_t              status_reg;
    logic [7:0]                      pixel_reg;
    logic [ppmp6_pkg::FIELD_W-1:0]   out_width_reg;
    logic [ppmp6_pkg::FIELD_W-1:0]   out_height_reg;
    logic [ppmp6_pkg::FIELD_W-1:0]   out_maxval_reg;

    ppmp6_pkg::ctrl_t   ctrl_next;
    logic [NB-1:0]      acc_next;
    logic [NB-1:0]      width_next;
    logic [NB-1:0]      height_next;
    logic [NB-1:0]      maxval_next;
    logic [CW-1:0]      count_next;
    ppmp6_pkg::status_t step_status;
    ppmp6_pkg::status_t status_next;
    logic [7:0]         pixel_next;
    logic               size_ok;
    logic               advance;
    logic               in_take;

    assign advance           = in_valid_reg && (!out_valid_reg || result.ready);
    assign byte_stream.ready = !in_valid_reg || advance;
    assign in_take           = byte_stream.valid && byte_stream.ready;

    ppmp6_step #(
        .NUMBER_BITS (NB)
    ) u_step (
        .data_byte   (in_byte_reg),
        .ctrl        (ctrl_reg),
        .acc         (acc_reg),
        .width_val   (width_reg),
        .height_val  (height_reg),
        .maxval_val  (maxval_reg),
        .ctrl_next   (ctrl_next),
        .acc_next    (acc_next),
        .width_next  (width_next),
        .height_next (height_next),
        .maxval_next (maxval_next),
        .status      (step_status)
    );

    assign prod_ext = EXT_W'(prod_reg);

    always_comb
    begin
        count_next = count_reg;
        if ((ctrl_reg.phase == ppmp6_pkg::PH_DATA) && (count_reg != ppmp6_pkg::COUNT_MAX))
            count_next = count_reg + CW'(1);
    end

    always_comb
    begin
        if (ctrl_reg.phase == ppmp6_pkg::PH_DATA)
            size_ok = !prod_big_reg && (NEED_W'(count_next) >= need_reg);
        else
            // last byte is the whitespace after maxval: no pixel bytes
            size_ok = (width_next == '0) || (height_next == '0);
    end

    always_comb
    begin
        pixel_next = (ctrl_reg.phase == ppmp6_pkg::PH_DATA) ? in_byte_reg : 8'h00;
        if (!in_last_reg)
            status_next = step_status;
        else if ((ctrl_next.phase == ppmp6_pkg::PH_DATA) && size_ok)
            status_next = ppmp6_pkg::ST_ACCEPT;
        else
            status_next = ppmp6_pkg::ST_REJECT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= ppmp6_pkg::CTRL_RESET;
            acc_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            maxval_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                if (in_last_reg)
                begin
                    ctrl_reg   <= ppmp6_pkg::CTRL_RESET;
                    acc_reg    <= '0;
                    width_reg  <= '0;
                    height_reg <= '0;
                    maxval_reg <= '0;
                    count_reg  <= '0;
                end
                else
                begin
                    ctrl_reg   <= ctrl_next;
                    acc_reg    <= acc_next;
                    width_reg  <= width_next;
                    height_reg <= height_next;
                    maxval_reg <= maxval_next;
                    count_reg  <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_stream.data_byte;
            in_last_reg <= byte_stream.last_byte;
        end

        prod_reg     <= PROD_W'(width_reg) * PROD_W'(height_reg);
        prod_big_reg <= prod_ext > EXT_W'(ppmp6_pkg::COUNT_MAX);
        need_reg     <= NEED_W'(prod_ext[CW-1:0]) * NEED_W'(BYTES_PER_PIXEL);

        if (advance)
        begin
            status_reg     <= status_next;
            pixel_reg      <= pixel_next;
            out_width_reg  <= ppmp6_pkg::FIELD_W'(width_next);
            out_height_reg <= ppmp6_pkg::FIELD_W'(height_next);
            out_maxval_reg <= ppmp6_pkg::FIELD_W'(maxval_next);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = status_reg;
    assign result.pixel_byte   = pixel_reg;
    assign result.image_width  = out_width_reg;
    assign result.image_height = out_height_reg;
    assign result.max_value    = out_maxval_reg;

endmodule

`default_nettype wire

### design/ppmp6_step.sv
// ---------------------------------------------------------------------------
// ppmp6_step
// Next-state logic of the header scanner for one byte.
// ---------------------------------------------------------------------------
`default_nettype none

module ppmp6_step #(
    parameter int NUMBER_BITS = ppmp6_pkg::NUMBER_BITS_DEF
) (
    input  wire logic [7:0]             data_byte,
    input  wire ppmp6_pkg::ctrl_t       ctrl,
    input  wire logic [NUMBER_BITS-1:0] acc,
    input  wire logic [NUMBER_BITS-1:0] width_val,
    input  wire logic [NUMBER_BITS-1:0] height_val,
    input  wire logic [NUMBER_BITS-1:0] maxval_val,
    output ppmp6_pkg::ctrl_t            ctrl_next,
    output logic [NUMBER_BITS-1:0]      acc_next,
    output logic [NUMBER_BITS-1:0]      width_next,
    output logic [NUMBER_BITS-1:0]      height_next,
    output logic [NUMBER_BITS-1:0]      maxval_next,
    output ppmp6_pkg::status_t          status
);

    localparam int MW = NUMBER_BITS + 4;

    logic          ws;
    logic          digit;
    logic [3:0]    digit_val;
    logic [MW-1:0] acc_mul;
    logic          overflow;
    logic          hdr;
    logic          btw;

    assign ws        = ppmp6_pkg::is_ws(data_byte);
    assign digit     = ppmp6_pkg::is_digit(data_byte);
    assign digit_val = data_byte[3:0];
    // acc * 10 + digit
    assign acc_mul   = (MW'(acc) << 3) + (MW'(acc) << 1) + MW'(digit_val);
    assign overflow  = |acc_mul[MW-1:NUMBER_BITS];

    always_comb
    begin
        ctrl_next   = ctrl;
        acc_next    = acc;
        width_next  = width_val;
        height_next = height_val;
        maxval_next = maxval_val;
        hdr         = 1'b0;
        btw         = 1'b0;

        case (ctrl.phase)
            ppmp6_pkg::PH_MAGIC:
            begin
                case (ctrl.magic_pos)
                    ppmp6_pkg::MPOS_FIRST:
                    begin
                        if (data_byte == ppmp6_pkg::CH_P)
                            ctrl_next.magic_pos = ppmp6_pkg::MPOS_SECOND;
                        else
                            ctrl_next.phase = ppmp6_pkg::PH_ERROR;
                    end
                    ppmp6_pkg::MPOS_SECOND:
                    begin
                        if (data_byte == ppmp6_pkg::CH_SIX)
                            ctrl_next.magic_pos = ppmp6_pkg::MPOS_THIRD;
                        else
                            ctrl_next.phase = ppmp6_pkg::PH_ERROR;
                    end
                    default:
                    begin
                        if (ws || (data_byte == ppmp6_pkg::CH_HASH))
                        begin
                            ctrl_next.phase = ppmp6_pkg::PH_HEADER;
                            hdr             = 1'b1;
                        end
                        else
                        begin
                            ctrl_next.phase = ppmp6_pkg::PH_ERROR;
                        end
                    end
                endcase
            end
            ppmp6_pkg::PH_HEADER:
            begin
                hdr = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (hdr)
        begin
            if (ctrl.in_comment)
            begin
                if (data_byte == ppmp6_pkg::CH_NL)
                    ctrl_next.in_comment = 1'b0;
            end
            else if (!ctrl.in_number)
            begin
                btw = 1'b1;
            end
            else if (digit)
            begin
                if (overflow)
                begin
                    ctrl_next.phase = ppmp6_pkg::PH_ERROR;
                end
                else
                begin
                    acc_next            = acc_mul[NUMBER_BITS-1:0];
                    ctrl_next.sign_seen = 1'b0;
                end
            end
            else if (ctrl.sign_seen)
            begin
                ctrl_next.phase = ppmp6_pkg::PH_ERROR;
            end
            else
            begin
                ctrl_next.in_number = 1'b0;
                acc_next            = '0;
                case (ctrl.field_idx)
                    ppmp6_pkg::FLD_WIDTH:
                    begin
                        width_next          = acc;
                        ctrl_next.field_idx = ppmp6_pkg::FLD_HEIGHT;
                        btw                 = 1'b1;
                    end
                    ppmp6_pkg::FLD_HEIGHT:
                    begin
                        height_next         = acc;
                        ctrl_next.field_idx = ppmp6_pkg::FLD_MAXVAL;
                        btw                 = 1'b1;
                    end
                    default:
                    begin
                        maxval_next         = acc;
                        ctrl_next.field_idx = ppmp6_pkg::FLD_DONE;
                        ctrl_next.phase     = ws ? ppmp6_pkg::PH_DATA : ppmp6_pkg::PH_ERROR;
                    end
                endcase
            end

            // byte outside a number and outside a comment
            if (btw && !ws)
            begin
                if (data_byte == ppmp6_pkg::CH_HASH)
                begin
                    ctrl_next.in_comment = 1'b1;
                end
                else if (digit)
                begin
                    ctrl_next.in_number = 1'b1;
                    ctrl_next.sign_seen = 1'b0;
                    acc_next            = NUMBER_BITS'(digit_val);
                end
                else if (data_byte == ppmp6_pkg::CH_PLUS)
                begin
                    ctrl_next.in_number = 1'b1;
                    ctrl_next.sign_seen = 1'b1;
                    acc_next            = '0;
                end
                else
                begin
                    ctrl_next.phase = ppmp6_pkg::PH_ERROR;
                end
            end
        end
    end

    always_comb
    begin
        if (ctrl.phase == ppmp6_pkg::PH_DATA)
            status = ppmp6_pkg::ST_PIXEL;
        else if (ctrl_next.phase == ppmp6_pkg::PH_ERROR)
            status = ppmp6_pkg::ST_ERROR;
        else
            status = ppmp6_pkg::ST_HEADER;
    end

endmodule

`default_nettype wire

### design/ppmp6_checker.sv
// ---------------------------------------------------------------------------
// ppmp6_checker
// Port-level checks on the result channel of the P6 header parser.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ppm_p6_header_parser_top_macros.svh"

module ppmp6_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] status,
    input wire logic [7:0] pixel_byte
);

    `PPMP6_ASSERT(a_valid_held, clk, rst_n, out_valid && !out_ready |=> out_valid, "result valid dropped before transfer")
    `PPMP6_ASSERT(a_payload_held, clk, rst_n, out_valid && !out_ready |=> $stable(status) && $stable(pixel_byte), "result payload changed while stalled")
    `PPMP6_ASSERT(a_status_code, clk, rst_n, out_valid |-> (status == ppmp6_pkg::ST_HEADER) || (status == ppmp6_pkg::ST_PIXEL) || (status == ppmp6_pkg::ST_ERROR) || (status == ppmp6_pkg::ST_ACCEPT) || (status == ppmp6_pkg::ST_REJECT), "undefined status code")
    `PPMP6_ASSERT_NEVER(a_no_stray_pixel, clk, rst_n, out_valid && ((status == ppmp6_pkg::ST_HEADER) || (status == ppmp6_pkg::ST_ERROR)) && (pixel_byte != 8'h00), "pixel byte on header or error result")

endmodule

bind ppm_p6_header_parser_top ppmp6_checker u_ppmp6_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (result.status),
    .pixel_byte (result.pixel_byte)
);

`default_nettype wire

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming P6 header parser.
// ---------------------------------------------------------------------------
// Sends whole files one byte per transfer: a few hand-written files, then
// random files under several idle and stall mixes. Most random files are
// well formed, with random whitespace, comments, signs, leading zeros, sizes
// and pixel counts. The rest have a corrupted byte, are cut short, or are
// noise. A scanner model in the bench predicts every result, and each result
// is compared field by field, in order, with its prediction.
`default_nettype none

module tb_top;

    localparam int          CYCLE_LIMIT = 500000;
    localparam logic [7:0]  CH_MINUS    = 8'h2D;
    localparam logic [31:0] NUM_LIMIT   = (32'd1 << ppmp6_pkg::NUMBER_BITS_DEF) - 32'd1;
    localparam logic [7:0]  BLANKS [6]  = '{ppmp6_pkg::CH_SPACE, ppmp6_pkg::CH_TAB,
                                            ppmp6_pkg::CH_NL, 8'h0B, 8'h0C,
                                            ppmp6_pkg::CH_CR};

    typedef struct {
        ppmp6_pkg::status_t status;
        logic [7:0]         pixel;
        logic [15:0]        width;
        logic [15:0]        height;
        logic [15:0]        maxval;
    } result_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ppmp6_byte_if   byte_bus ();
    ppmp6_result_if res_bus ();

    ppm_p6_header_parser_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_bus),
        .result      (res_bus)
    );

    always #5 clk = ~clk;

    // scanner model state
    ppmp6_pkg::phase_t scan_phase;
    logic [1:0]        scan_mpos;
    logic [1:0]        scan_field;
    bit                scan_comment;
    bit                scan_number;
    bit                scan_sign;
    logic [31:0]       scan_acc;
    logic [15:0]       scan_width;
    logic [15:0]       scan_height;
    logic [15:0]       scan_maxval;
    logic [33:0]       scan_count;

    result_rec_t  pending_results[$];
    result_rec_t  want;
    logic [7:0]   file_bytes[$];

    int unsigned  send_idle      = 0;
    int unsigned  recv_stall     = 0;
    int unsigned  mismatches     = 0;
    int unsigned  cycles         = 0;
    int unsigned  files_sent     = 0;
    int unsigned  bytes_sent     = 0;
    int unsigned  results_seen   = 0;
    int unsigned  files_accepted = 0;
    int unsigned  files_rejected = 0;
    int unsigned  pixels_seen    = 0;

    function automatic bit blank_char(input logic [7:0] c);
        return (c == ppmp6_pkg::CH_SPACE) || (c >= ppmp6_pkg::CH_TAB && c <= ppmp6_pkg::CH_CR);
    endfunction

    function automatic bit decimal_char(input logic [7:0] c);
        return c >= ppmp6_pkg::CH_ZERO && c <= ppmp6_pkg::CH_NINE;
    endfunction

    task automatic clear_scanner();
        scan_phase   = ppmp6_pkg::PH_MAGIC;
        scan_mpos    = ppmp6_pkg::MPOS_FIRST;
        scan_field   = ppmp6_pkg::FLD_WIDTH;
        scan_comment = 1'b0;
        scan_number  = 1'b0;
        scan_sign    = 1'b0;
        scan_acc     = '0;
        scan_width   = '0;
        scan_height  = '0;
        scan_maxval  = '0;
        scan_count   = '0;
    endtask

    task automatic start_token(input logic [7:0] c);
        if (blank_char(c))
        begin
        end
        else if (c == ppmp6_pkg::CH_HASH)
        begin
            scan_comment = 1'b1;
        end
        else if (decimal_char(c))
        begin
            scan_number = 1'b1;
            scan_sign   = 1'b0;
            scan_acc    = 32'(c - ppmp6_pkg::CH_ZERO);
        end
        else if (c == ppmp6_pkg::CH_PLUS)
        begin
            scan_number = 1'b1;
            scan_sign   = 1'b1;
            scan_acc    = '0;
        end
        else
        begin
            scan_phase = ppmp6_pkg::PH_ERROR;
        end
    endtask

    task automatic scan_header(input logic [7:0] c);
        logic [31:0] next_val;
        if (scan_comment)
        begin
            if (c == ppmp6_pkg::CH_NL)
                scan_comment = 1'b0;
        end
        else if (!scan_number)
        begin
            start_token(c);
        end
        else if (decimal_char(c))
        begin
            next_val = scan_acc * 32'd10 + 32'(c - ppmp6_pkg::CH_ZERO);
            if (next_val > NUM_LIMIT)
            begin
                scan_phase = ppmp6_pkg::PH_ERROR;
            end
            else
            begin
                scan_acc  = next_val;
                scan_sign = 1'b0;
            end
        end
        else if (scan_sign)
        begin
            scan_phase = ppmp6_pkg::PH_ERROR;
        end
        else
        begin
            scan_number = 1'b0;
            case (scan_field)
                ppmp6_pkg::FLD_WIDTH:
                begin
                    scan_width = scan_acc[15:0];
                    scan_field = ppmp6_pkg::FLD_HEIGHT;
                    start_token(c);
                end
                ppmp6_pkg::FLD_HEIGHT:
                begin
                    scan_height = scan_acc[15:0];
                    scan_field  = ppmp6_pkg::FLD_MAXVAL;
                    start_token(c);
                end
                default:
                begin
                    scan_maxval = scan_acc[15:0];
                    scan_field  = ppmp6_pkg::FLD_DONE;
                    scan_phase  = blank_char(c) ? ppmp6_pkg::PH_DATA : ppmp6_pkg::PH_ERROR;
                end
            endcase
            scan_acc = '0;
        end
    endtask

    task automatic predict_byte(input logic [7:0] c, input bit last, output result_rec_t r);
        logic [35:0] required;
        bit          ok;
        r.status = ppmp6_pkg::ST_HEADER;
        r.pixel  = '0;
        if (scan_phase == ppmp6_pkg::PH_DATA)
        begin
            if (scan_count != ppmp6_pkg::COUNT_MAX)
                scan_count = scan_count + 34'd1;
            r.pixel  = c;
            r.status = ppmp6_pkg::ST_PIXEL;
        end
        else if (scan_phase == ppmp6_pkg::PH_MAGIC)
        begin
            if (scan_mpos == ppmp6_pkg::MPOS_FIRST)
            begin
                if (c == ppmp6_pkg::CH_P) scan_mpos = ppmp6_pkg::MPOS_SECOND;
                else scan_phase = ppmp6_pkg::PH_ERROR;
            end
            else if (scan_mpos == ppmp6_pkg::MPOS_SECOND)
            begin
                if (c == ppmp6_pkg::CH_SIX) scan_mpos = ppmp6_pkg::MPOS_THIRD;
                else scan_phase = ppmp6_pkg::PH_ERROR;
            end
            else if (blank_char(c) || c == ppmp6_pkg::CH_HASH)
            begin
                scan_phase = ppmp6_pkg::PH_HEADER;
                scan_header(c);
            end
            else
            begin
                scan_phase = ppmp6_pkg::PH_ERROR;
            end
        end
        else if (scan_phase == ppmp6_pkg::PH_HEADER)
        begin
            scan_header(c);
        end
        if (scan_phase == ppmp6_pkg::PH_ERROR)
            r.status = ppmp6_pkg::ST_ERROR;
        if (last)
        begin
            ok = 1'b0;
            if (scan_phase == ppmp6_pkg::PH_DATA)
            begin
                required = 36'(scan_width) * 36'(scan_height)
                           * 36'(ppmp6_pkg::BYTES_PER_PIXEL_DEF);
                ok = 36'(scan_count) >= required;
            end
            r.status = ok ? ppmp6_pkg::ST_ACCEPT : ppmp6_pkg::ST_REJECT;
        end
        r.width  = scan_width;
        r.height = scan_height;
        r.maxval = scan_maxval;
        if (last)
            clear_scanner();
    endtask

    task automatic send_byte(input logic [7:0] c, input bit last);
        result_rec_t r;
        while ($urandom_range(99) < send_idle)
        begin
            byte_bus.valid <= 1'b0;
            @(posedge clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= c;
        byte_bus.last_byte <= last;
        @(posedge clk);
        while (!byte_bus.ready)
            @(posedge clk);
        predict_byte(c, last, r);
        pending_results.push_back(r);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        return BLANKS[$urandom_range(5)];
    endfunction

    function automatic logic [7:0] pick_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic push_number(input int unsigned v);
        int unsigned pad;
        if ($urandom_range(3) == 0)
            file_bytes.push_back(ppmp6_pkg::CH_PLUS);
        pad = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0;
        repeat (pad)
            file_bytes.push_back(ppmp6_pkg::CH_ZERO);
        push_text($sformatf("%0d", v));
    endtask

    // whitespace and comments between header fields, never empty
    task automatic push_gap();
        logic [7:0] c;
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(3) == 0)
            begin
                file_bytes.push_back(ppmp6_pkg::CH_HASH);
                repeat ($urandom_range(0, 4))
                begin
                    c = pick_byte();
                    if (c == ppmp6_pkg::CH_NL)
                        c = ppmp6_pkg::CH_SPACE;
                    file_bytes.push_back(c);
                end
                file_bytes.push_back(ppmp6_pkg::CH_NL);
            end
            else
            begin
                file_bytes.push_back(pick_blank());
            end
        end
    endtask

    function automatic int unsigned pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80) return $urandom_range(0, 4);
        if (roll < 90) return $urandom_range(0, 65535);
        if (roll < 96) return 65535;
        return $urandom_range(65536, 99999);
    endfunction

    function automatic int unsigned pick_maxval();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return 255;
        if (roll < 55) return 65535;
        if (roll < 60) return 0;
        if (roll < 96) return $urandom_range(0, 65535);
        return $urandom_range(65536, 99999);
    endfunction

    task automatic build_file();
        int unsigned     w;
        int unsigned     h;
        int              npix;
        int              keep;
        int unsigned     pos;
        longint unsigned need;
        file_bytes.delete();
        if ($urandom_range(19) == 0)
        begin
            if ($urandom_range(1) == 0)
                push_text("P6");
            repeat ($urandom_range(1, 12))
                file_bytes.push_back(pick_byte());
        end
        else
        begin
            w = pick_dim();
            h = pick_dim();
            push_text("P6");
            push_gap();
            push_number(w);
            push_gap();
            push_number(h);
            push_gap();
            push_number(pick_maxval());
            if ($urandom_range(9) == 0)
                file_bytes.push_back(pick_byte());
            else
                file_bytes.push_back(pick_blank());
            need = longint'(w) * longint'(h) * ppmp6_pkg::BYTES_PER_PIXEL_DEF;
            if (need <= 48)
            begin
                npix = int'(need);
                if ($urandom_range(1) == 0)
                    npix = npix + $urandom_range(0, 4) - 2;
                if (npix < 0)
                    npix = 0;
            end
            else
            begin
                npix = $urandom_range(0, 8);
            end
            repeat (npix)
                file_bytes.push_back(pick_byte());
            if ($urandom_range(4) == 0)
            begin
                pos = $urandom_range(file_bytes.size() - 1);
                case ($urandom_range(3))
                    0: file_bytes[pos] = CH_MINUS;
                    1: file_bytes[pos] = ppmp6_pkg::CH_PLUS;
                    2: file_bytes[pos] = ppmp6_pkg::CH_HASH;
                    default: file_bytes[pos] = pick_byte();
                endcase
            end
            if ($urandom_range(7) == 0 && file_bytes.size() > 1)
            begin
                keep = $urandom_range(1, file_bytes.size() - 1);
                file_bytes = file_bytes[0:keep-1];
            end
        end
    endtask

    task automatic test_bad_magic();
        file_bytes.delete();
        push_text("P7");
        send_file();
    endtask

    task automatic test_sign_and_overflow();
        file_bytes.delete();
        push_text("P6 -");
        send_file();
        file_bytes.delete();
        push_text("P6\t65536");
        send_file();
    endtask

    // comment as third byte, zero area, file ends on the byte after maxval
    task automatic test_empty_image();
        file_bytes.delete();
        push_text("P6#\n0 0 +7 ");
        send_file();
    endtask

    task automatic test_min_image();
        file_bytes.delete();
        push_text("P6 1 1 9\n");
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hA5);
        send_file();
    endtask

    task automatic test_random_files(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned byte_target);
        int unsigned start;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        start      = bytes_sent;
        while (bytes_sent - start < byte_target)
        begin
            build_file();
            send_file();
        end
    endtask

    always @(posedge clk)
        res_bus.ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no transfer outstanding, status %0d", res_bus.status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_bus.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_bus.status);
                    mismatches++;
                end
                if (res_bus.pixel_byte !== want.pixel)
                begin
                    $error("pixel_byte: expected %0d, got %0d", want.pixel, res_bus.pixel_byte);
                    mismatches++;
                end
                if (res_bus.image_width !== want.width)
                begin
                    $error("image_width: expected %0d, got %0d", want.width,
                           res_bus.image_width);
                    mismatches++;
                end
                if (res_bus.image_height !== want.height)
                begin
                    $error("image_height: expected %0d, got %0d", want.height,
                           res_bus.image_height);
                    mismatches++;
                end
                if (res_bus.max_value !== want.maxval)
                begin
                    $error("max_value: expected %0d, got %0d", want.maxval, res_bus.max_value);
                    mismatches++;
                end
                if (want.status == ppmp6_pkg::ST_ACCEPT) files_accepted++;
                if (want.status == ppmp6_pkg::ST_REJECT) files_rejected++;
                if (want.status == ppmp6_pkg::ST_PIXEL) pixels_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        byte_bus.valid     <= 1'b0;
        byte_bus.data_byte <= '0;
        byte_bus.last_byte <= 1'b0;
        clear_scanner();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bad_magic();
        test_sign_and_overflow();
        test_empty_image();
        test_min_image();
        test_random_files(0, 0, 500);
        test_random_files(64, 0, 500);
        test_random_files(0, 64, 500);
        test_random_files(32, 32, 500);

        byte_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("tb_top: %0d files, %0d bytes sent, %0d results checked",
                 files_sent, bytes_sent, results_seen);
        $display("tb_top: %0d files accepted, %0d rejected, %0d pixel bytes passed",
                 files_accepted, files_rejected, pixels_seen);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

### ppm_p6_header_parser_top.f
+incdir+design
design/ppmp6_pkg.sv
design/ppmp6_if.sv
design/ppmp6_step.sv
design/ppm_p6_header_parser_top.sv
design/ppmp6_checker.sv
tb/tb_top.sv
